// ===== hdl/fletcher16_frame_builder_top_assert.svh =====
// Assertion macros for the frame builder.
// Each macro takes a label, the clock, the reset, an antecedent, a consequent
// and a message string.
`ifndef FLETCHER16_FRAME_BUILDER_TOP_ASSERT_SVH
`define FLETCHER16_FRAME_BUILDER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define F16FB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define F16FB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define F16FB_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define F16FB_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/f16fb_pkg.sv =====
package f16fb_pkg;

  // Command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Frame overhead: four sync bytes, two length bytes, two check bytes
  localparam int unsigned FRAME_OVERHEAD = 8;

  localparam logic [7:0] SYNC_BYTES [4] = '{8'h55, 8'h4D, 8'h52, 8'h56};

  // Fletcher sums restart here at every frame
  localparam logic [7:0] SUM_INIT = 8'hFF;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte position inside one job; a header with check bytes is the longest
  localparam int unsigned IDX_W = 3;

  typedef enum logic [1:0] {
    JOB_DROP,
    JOB_HEADER,
    JOB_PAYLOAD
  } job_kind_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
  } sums_t;

  // One classified command waiting for the back end
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;    // length low byte or payload byte
    logic [7:0] b1;    // length high byte
    logic       last;  // check bytes follow; also set on drop jobs
    sums_t      sums;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } queue_stat_t;

  // (a + b) mod 255 for a, b up to 255
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s == 9'd510) begin
      return 8'd0;
    end else if (s >= 9'd255) begin
      return 8'(s - 9'd255);
    end else begin
      return s[7:0];
    end
  endfunction

  function automatic sums_t absorb(input sums_t s, input logic [7:0] b);
    sums_t r;
    r.lo = add_mod255(s.lo, b);
    r.hi = add_mod255(s.hi, r.lo);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] job_last_idx(input job_t j);
    case (j.kind)
      JOB_DROP:    return IDX_W'(0);
      JOB_HEADER:  return j.last ? IDX_W'(7) : IDX_W'(5);
      JOB_PAYLOAD: return j.last ? IDX_W'(2) : IDX_W'(0);
      default:     return IDX_W'(0);
    endcase
  endfunction

endpackage

// ===== hdl/f16fb_in_if.sv =====
interface f16fb_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, command, payload_length, data_byte, input ready);
  modport sink   (input valid, command, payload_length, data_byte, output ready);
endinterface

// ===== hdl/f16fb_out_if.sv =====
interface f16fb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       dropped;

  modport source (output valid, out_byte, frame_end, dropped, input ready);
  modport sink   (input valid, out_byte, frame_end, dropped, output ready);
endinterface

// ===== hdl/fletcher16_frame_builder_top.sv =====
// Fletcher-16 frame builder. Each command item is taken while the four-entry
// job queue has room; the front end classifies it (start, payload, or a
// payload with no open frame, which is swallowed) and keeps the running
// Fletcher sums, so the checksum is complete the moment the item is accepted.
// The back end turns each job into output bytes at one byte per cycle while
// the output is ready, through a registered output stage: a payload byte gives
// one byte (three on the last payload byte, adding the low then high check
// byte), a start gives six bytes of sync and length (eight for a zero length
// frame), and an oversize start gives a single zero byte flagged dropped and
// frame_end. Sustained rate is therefore one item per cycle for payload
// streams while the output does not stall, and the queue absorbs up to four
// pending jobs before cmd.ready falls. An accepted job is written into the
// queue and then loaded into the output register before its first byte shows.
module fletcher16_frame_builder_top #(
  parameter int unsigned MAX_FRAME_BYTES = 512
) (
  input  logic          clk,
  input  logic          rst,
  f16fb_in_if.sink      cmd,
  f16fb_out_if.source   stream
);

  `include "fletcher16_frame_builder_top_assert.svh"

  logic                    push_valid;
  logic                    push_ready;
  f16fb_pkg::job_t         push_job;
  logic                    job_valid;
  logic                    pop;
  f16fb_pkg::job_t         job;
  f16fb_pkg::queue_stat_t  q_stat;

  // Classify commands and track the open frame and its sums
  f16fb_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Hold jobs so the front keeps taking items while the output stalls
  f16fb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (job_valid),
    .pop        (pop),
    .pop_job    (job),
    .stat       (q_stat)
  );

  // Expand each job into framed bytes
  f16fb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .stream    (stream)
  );

  // A drop result is always a lone zero byte that closes the frame
  `F16FB_ASSERT_IMP(a_drop_shape, clk, rst, stream.valid && stream.dropped, stream.frame_end && (stream.out_byte == 8'd0), "drop result malformed")

  // An empty queue never stalls the command side
  `F16FB_ASSERT_IMP(a_empty_ready, clk, rst, q_stat.empty, cmd.ready, "ready low with empty queue")

  // The queue occupancy stays within its depth
  `F16FB_ASSERT_NXT(a_queue_bound, clk, rst, 1'b1, q_stat.count <= f16fb_pkg::QCNT_W'(f16fb_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== hdl/f16fb_front.sv =====
module f16fb_front #(
  parameter int unsigned MAX_FRAME_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst,
  f16fb_in_if.sink          cmd,
  output logic              push_valid,
  input  logic              push_ready,
  output f16fb_pkg::job_t   push_job
);

  logic                in_frame;
  logic [15:0]         bytes_left;
  f16fb_pkg::sums_t    sums;

  logic                in_frame_next;
  logic [15:0]         bytes_left_next;
  f16fb_pkg::sums_t    sums_next;

  logic                accept;
  logic [16:0]         total;
  f16fb_pkg::sums_t    seed;
  f16fb_pkg::sums_t    hdr_sums;
  f16fb_pkg::sums_t    pay_sums;

  assign cmd.ready = push_ready;
  assign accept    = cmd.valid && cmd.ready;

  assign total    = {1'b0, cmd.payload_length} + 17'(f16fb_pkg::FRAME_OVERHEAD);
  assign seed     = '{lo: f16fb_pkg::SUM_INIT, hi: f16fb_pkg::SUM_INIT};
  assign hdr_sums = f16fb_pkg::absorb(f16fb_pkg::absorb(seed, cmd.payload_length[7:0]),
                                      cmd.payload_length[15:8]);
  assign pay_sums = f16fb_pkg::absorb(sums, cmd.data_byte);

  always_comb begin
    in_frame_next   = in_frame;
    bytes_left_next = bytes_left;
    sums_next       = sums;
    push_valid      = 1'b0;
    push_job        = '{kind: f16fb_pkg::JOB_DROP, b0: 8'd0, b1: 8'd0, last: 1'b0,
                        sums: '0};
    if (accept) begin
      if (cmd.command == f16fb_pkg::CMD_START) begin
        push_valid = 1'b1;
        if (total > 17'(MAX_FRAME_BYTES)) begin
          // oversize: close any open frame
          in_frame_next   = 1'b0;
          bytes_left_next = 16'd0;
          push_job.last   = 1'b1;
        end else begin
          in_frame_next   = (cmd.payload_length != 16'd0);
          bytes_left_next = cmd.payload_length;
          sums_next       = hdr_sums;
          push_job.kind   = f16fb_pkg::JOB_HEADER;
          push_job.b0     = cmd.payload_length[7:0];
          push_job.b1     = cmd.payload_length[15:8];
          push_job.last   = (cmd.payload_length == 16'd0);
          push_job.sums   = hdr_sums;
        end
      end else if (in_frame) begin
        push_valid      = 1'b1;
        bytes_left_next = bytes_left - 16'd1;
        in_frame_next   = (bytes_left != 16'd1);
        sums_next       = pay_sums;
        push_job.kind   = f16fb_pkg::JOB_PAYLOAD;
        push_job.b0     = cmd.data_byte;
        push_job.last   = (bytes_left == 16'd1);
        push_job.sums   = pay_sums;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= 16'd0;
      sums       <= '0;
    end else begin
      in_frame   <= in_frame_next;
      bytes_left <= bytes_left_next;
      sums       <= sums_next;
    end
  end

endmodule

// ===== hdl/f16fb_queue.sv =====
module f16fb_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  f16fb_pkg::job_t         push_job,
  output logic                    pop_valid,
  input  logic                    pop,
  output f16fb_pkg::job_t         pop_job,
  output f16fb_pkg::queue_stat_t  stat
);

  f16fb_pkg::job_t                   mem [f16fb_pkg::QUEUE_DEPTH];
  logic [f16fb_pkg::QPTR_W-1:0]      wr_ptr;
  logic [f16fb_pkg::QPTR_W-1:0]      rd_ptr;
  logic [f16fb_pkg::QCNT_W-1:0]      count;
  logic                              do_push;
  logic                              do_pop;

  assign stat.count = count;
  assign stat.full  = (count == f16fb_pkg::QCNT_W'(f16fb_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_job    = mem[rd_ptr];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/f16fb_back.sv =====
module f16fb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  f16fb_pkg::job_t   job,
  output logic              pop,
  f16fb_out_if.source       stream
);

  logic [f16fb_pkg::IDX_W-1:0] idx;
  logic [f16fb_pkg::IDX_W-1:0] last_idx;
  logic                        load;
  logic [7:0]                  byte_sel;
  logic                        end_sel;
  logic                        drop_sel;

  logic                        out_valid;
  logic [7:0]                  out_byte;
  logic                        frame_end;
  logic                        dropped;

  assign last_idx = f16fb_pkg::job_last_idx(job);
  assign load     = job_valid && (!out_valid || stream.ready);
  assign pop      = load && (idx == last_idx);

  always_comb begin
    byte_sel = 8'd0;
    drop_sel = 1'b0;
    end_sel  = (idx == last_idx) && job.last;
    case (job.kind)
      f16fb_pkg::JOB_DROP: begin
        drop_sel = 1'b1;
        end_sel  = 1'b1;
      end
      f16fb_pkg::JOB_HEADER: begin
        case (idx)
          3'd4:    byte_sel = job.b0;
          3'd5:    byte_sel = job.b1;
          3'd6:    byte_sel = job.sums.lo;
          3'd7:    byte_sel = job.sums.hi;
          default: byte_sel = f16fb_pkg::SYNC_BYTES[idx[1:0]];
        endcase
      end
      f16fb_pkg::JOB_PAYLOAD: begin
        case (idx)
          3'd1:    byte_sel = job.sums.lo;
          3'd2:    byte_sel = job.sums.hi;
          default: byte_sel = job.b0;
        endcase
      end
      default: begin
        byte_sel = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= pop ? '0 : idx + 1'b1;
      end else if (stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= byte_sel;
      frame_end <= end_sel;
      dropped   <= drop_sel;
    end
  end

  assign stream.valid     = out_valid;
  assign stream.out_byte  = out_byte;
  assign stream.frame_end = frame_end;
  assign stream.dropped   = dropped;

endmodule
